### src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared widths, opcodes, request and result types, and the cell's carry record.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WIDTH     = 32;
  localparam int FRAC_BITS = 8;
  // Quotient bits of the widened dividend.
  localparam int QBITS     = WIDTH + FRAC_BITS;
  localparam int NCELLS    = QBITS;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT  = 4'd4, OP_GT  = 4'd5, OP_LE  = 4'd6, OP_GE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_word;
    logic               compare_true;
    logic               divide_by_zero;
  } fpa_out_t;

  // Record moved from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic              dz;
    logic [WIDTH-1:0]  other;   // result of the non-divide path
    logic              cmp;
    logic [WIDTH:0]    rem;     // partial remainder
    logic [QBITS-1:0]  dvd;     // dividend bits, shifted into quotient bits
    logic [WIDTH-1:0]  dvs;     // divisor magnitude
  } fpa_slot_t;

endpackage

### src/fpa_cell.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring-division step; passes the request to the next cell when allowed.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  fpa_pkg::fpa_slot_t slot_in,
  output fpa_pkg::fpa_slot_t slot_out
);
  import fpa_pkg::*;

  fpa_slot_t slot_r, slot_nxt;
  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;

  // Shift in the next dividend bit and try subtracting the divisor.
  always_comb begin
    slot_nxt = slot_in;
    trial    = {slot_in.rem[WIDTH-1:0], slot_in.dvd[QBITS-1]};
    diff     = trial - {1'b0, slot_in.dvs};
    if (!diff[WIDTH]) begin
      slot_nxt.rem = diff;
    end else begin
      slot_nxt.rem = trial;
    end
    slot_nxt.dvd = {slot_in.dvd[QBITS-2:0], ~diff[WIDTH]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (adv) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;

endmodule

### src/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed Q24.8 ALU with a pipelined divider built from a chain of cells.
// ----------------------------------------------------------------------------
// Every request passes through the entry register, the chain of one-bit
// restoring-division cells and the output register, whatever the opcode;
// a new request is accepted every cycle while the output side keeps taking
// results. The multiply product is registered in the entry stage.
module fixed_point_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpa_pkg::fpa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fpa_pkg::fpa_out_t out_data
);
  import fpa_pkg::*;

  logic adv;
  logic signed [WIDTH-1:0] a, b;
  logic signed [2*WIDTH-1:0] prod;
  logic lt, gt, eq;
  fpa_slot_t head;
  fpa_slot_t chain [NCELLS+1];
  fpa_out_t out_r, out_nxt;
  logic out_valid_r;
  logic [WIDTH-1:0] a_mag, b_mag, q;

  // Pipeline moves when the output register is empty or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Entry stage: everything but the divide is done here.
  always_comb begin
    a    = in_data.operand_a;
    b    = in_data.operand_b;
    prod = a * b;
    lt   = a < b;
    gt   = b < a;
    eq   = a == b;
    a_mag = a[WIDTH-1] ? WIDTH'(-a) : a;
    b_mag = b[WIDTH-1] ? WIDTH'(-b) : b;
    head = '0;
    head.valid  = in_valid;
    head.is_div = in_data.opcode == OP_DIV;
    head.neg    = a[WIDTH-1] ^ b[WIDTH-1];
    head.dz     = (in_data.opcode == OP_DIV) && (b == '0);
    head.dvd    = {a_mag, {FRAC_BITS{1'b0}}};
    head.dvs    = b_mag;
    case (opcode_t'(in_data.opcode))
      OP_ADD:      head.other = a + b;
      OP_SUB:      head.other = a - b;
      OP_MUL:      head.other = prod[FRAC_BITS +: WIDTH];
      OP_LT:       head.cmp = lt;
      OP_GT:       head.cmp = gt;
      OP_LE:       head.cmp = !gt;
      OP_GE:       head.cmp = !lt;
      OP_EQ:       head.cmp = eq;
      OP_NE:       head.cmp = !eq;
      OP_MIN:      head.other = lt ? a : b;
      OP_MAX:      head.other = gt ? a : b;
      OP_INC:      head.other = a + WIDTH'(1);
      OP_DEC:      head.other = a - WIDTH'(1);
      OP_FROM_INT: head.other = a <<< FRAC_BITS;
      OP_TO_INT:   head.other = a >>> FRAC_BITS;
      default:     head.other = '0;
    endcase
  end

  // Entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0] <= head;
    end
  end

  // Chain of division cells.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .slot_in (chain[i]),
      .slot_out(chain[i+1])
    );
  end

  // Output selection: the quotient keeps its low WIDTH bits.
  always_comb begin
    q = chain[NCELLS].dvd[WIDTH-1:0];
    out_nxt = '0;
    out_nxt.compare_true = chain[NCELLS].cmp;
    if (chain[NCELLS].is_div) begin
      if (chain[NCELLS].dz) begin
        out_nxt.divide_by_zero = 1'b1;
      end else begin
        out_nxt.result_word = chain[NCELLS].neg ? -q : q;
      end
    end else begin
      out_nxt.result_word = chain[NCELLS].other;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NCELLS].valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // Ready follows the output register.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled with empty output");
  // Flags are exclusive.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.compare_true && out_data.divide_by_zero))
    else $error("both flags set");

endmodule
